FILE: hdl/euler_lax_wendroff_flux_defines.svh
// Assertion macros used by the flux block's top-level RTL file.
`ifndef EULER_LAX_WENDROFF_FLUX_DEFINES_SVH
`define EULER_LAX_WENDROFF_FLUX_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ELW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("elw assertion failed");

// Next-cycle implication, disabled during reset.
`define ELW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("elw assertion failed");

`endif

FILE: hdl/elw_pkg.sv
// Types, constants and the operation sequence of the Lax-Wendroff flux block.
`timescale 1ns / 1ps
`default_nettype none
package elw_pkg;

	localparam int DW = 32;
	localparam int FW = 16;
	localparam int QW = DW + FW;
	localparam int PW = 2 * DW;
	localparam int CW = 31;
	localparam int REG_DEPTH = 16;
	localparam int PC_W = 6;
	localparam int DIV_CNT_W = $clog2(QW + 1);

	localparam logic [CW-1:0] GAMMA_RESET = CW'(26214);
	localparam logic CFG_HALF_DT = 1'b0;
	localparam logic CFG_GAMMA = 1'b1;
	localparam logic [PC_W-1:0] STORE_PC = PC_W'(36);

	typedef struct packed {
		logic [30:0]        cell_density;
		logic signed [31:0] cell_momentum;
		logic signed [31:0] cell_energy;
		logic               row_start;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] flux_mass;
		logic signed [31:0] flux_momentum;
		logic signed [31:0] flux_energy;
		logic               arith_fault;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_MOV, OP_ADD, OP_SUB, OP_AVG, OP_HALF, OP_MUL, OP_DIV
	} op_t;

	typedef enum logic [2:0] {
		SRC_RAM, SRC_RHO, SRC_MOM, SRC_EN, SRC_ALPHA, SRC_GAMMA
	} src_t;

	typedef enum logic [3:0] {
		R_PL_RHO, R_PL_M, R_PL_E, R_PL_A1, R_PL_A2, R_NA1, R_NA2,
		R_U, R_KE, R_X, R_P, R_Y, R_RS, R_MS, R_ES
	} reg_id_t;

	typedef enum logic [1:0] {
		CAP_NONE, CAP_MASS, CAP_MOM, CAP_EN
	} cap_t;

	typedef struct packed {
		op_t     op;
		src_t    a_src;
		reg_id_t a_reg;
		src_t    b_src;
		reg_id_t b_reg;
		reg_id_t dst;
		cap_t    cap;
		logic    br;
		logic    last;
	} uop_t;

	function automatic uop_t mk(op_t op, src_t as, reg_id_t ar, src_t bs, reg_id_t brg,
			reg_id_t dst, cap_t cap, logic br, logic last);
		uop_t u;
		u.op = op;
		u.a_src = as;
		u.a_reg = ar;
		u.b_src = bs;
		u.b_reg = brg;
		u.dst = dst;
		u.cap = cap;
		u.br = br;
		u.last = last;
		return u;
	endfunction

	// Cell terms of the new cell, the left cell (faults only), the three
	// half-step states, the interface fluxes, then the store of the new cell.
	function automatic uop_t prog(logic [PC_W-1:0] pc);
		uop_t u;
		unique case (pc)
			6'd0:  u = mk(OP_DIV, SRC_MOM, R_X, SRC_RHO, R_X, R_U, CAP_NONE, 1'b0, 1'b0);
			6'd1:  u = mk(OP_MUL, SRC_MOM, R_X, SRC_RAM, R_U, R_KE, CAP_NONE, 1'b0, 1'b0);
			6'd2:  u = mk(OP_HALF, SRC_RAM, R_KE, SRC_RAM, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd3:  u = mk(OP_SUB, SRC_EN, R_X, SRC_RAM, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd4:  u = mk(OP_MUL, SRC_GAMMA, R_X, SRC_RAM, R_X, R_P, CAP_NONE, 1'b0, 1'b0);
			6'd5:  u = mk(OP_ADD, SRC_RAM, R_KE, SRC_RAM, R_P, R_NA1, CAP_NONE, 1'b0, 1'b0);
			6'd6:  u = mk(OP_ADD, SRC_EN, R_X, SRC_RAM, R_P, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd7:  u = mk(OP_MUL, SRC_RAM, R_U, SRC_RAM, R_X, R_NA2, CAP_NONE, 1'b1, 1'b0);
			6'd8:  u = mk(OP_DIV, SRC_RAM, R_PL_M, SRC_RAM, R_PL_RHO, R_U, CAP_NONE,
					1'b0, 1'b0);
			6'd9:  u = mk(OP_MUL, SRC_RAM, R_PL_M, SRC_RAM, R_U, R_KE, CAP_NONE, 1'b0, 1'b0);
			6'd10: u = mk(OP_HALF, SRC_RAM, R_KE, SRC_RAM, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd11: u = mk(OP_SUB, SRC_RAM, R_PL_E, SRC_RAM, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd12: u = mk(OP_MUL, SRC_GAMMA, R_X, SRC_RAM, R_X, R_P, CAP_NONE, 1'b0, 1'b0);
			6'd13: u = mk(OP_ADD, SRC_RAM, R_KE, SRC_RAM, R_P, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd14: u = mk(OP_ADD, SRC_RAM, R_PL_E, SRC_RAM, R_P, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd15: u = mk(OP_MUL, SRC_RAM, R_U, SRC_RAM, R_X, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd16: u = mk(OP_AVG, SRC_RAM, R_PL_RHO, SRC_RHO, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd17: u = mk(OP_SUB, SRC_MOM, R_X, SRC_RAM, R_PL_M, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd18: u = mk(OP_MUL, SRC_ALPHA, R_X, SRC_RAM, R_Y, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd19: u = mk(OP_SUB, SRC_RAM, R_X, SRC_RAM, R_Y, R_RS, CAP_NONE, 1'b0, 1'b0);
			6'd20: u = mk(OP_AVG, SRC_RAM, R_PL_M, SRC_MOM, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd21: u = mk(OP_SUB, SRC_RAM, R_NA1, SRC_RAM, R_PL_A1, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd22: u = mk(OP_MUL, SRC_ALPHA, R_X, SRC_RAM, R_Y, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd23: u = mk(OP_SUB, SRC_RAM, R_X, SRC_RAM, R_Y, R_MS, CAP_MASS, 1'b0, 1'b0);
			6'd24: u = mk(OP_AVG, SRC_RAM, R_PL_E, SRC_EN, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd25: u = mk(OP_SUB, SRC_RAM, R_NA2, SRC_RAM, R_PL_A2, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd26: u = mk(OP_MUL, SRC_ALPHA, R_X, SRC_RAM, R_Y, R_Y, CAP_NONE, 1'b0, 1'b0);
			6'd27: u = mk(OP_SUB, SRC_RAM, R_X, SRC_RAM, R_Y, R_ES, CAP_NONE, 1'b0, 1'b0);
			6'd28: u = mk(OP_DIV, SRC_RAM, R_MS, SRC_RAM, R_RS, R_U, CAP_NONE, 1'b0, 1'b0);
			6'd29: u = mk(OP_MUL, SRC_RAM, R_MS, SRC_RAM, R_U, R_KE, CAP_NONE, 1'b0, 1'b0);
			6'd30: u = mk(OP_HALF, SRC_RAM, R_KE, SRC_RAM, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd31: u = mk(OP_SUB, SRC_RAM, R_ES, SRC_RAM, R_X, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd32: u = mk(OP_MUL, SRC_GAMMA, R_X, SRC_RAM, R_X, R_P, CAP_NONE, 1'b0, 1'b0);
			6'd33: u = mk(OP_ADD, SRC_RAM, R_KE, SRC_RAM, R_P, R_Y, CAP_MOM, 1'b0, 1'b0);
			6'd34: u = mk(OP_ADD, SRC_RAM, R_ES, SRC_RAM, R_P, R_X, CAP_NONE, 1'b0, 1'b0);
			6'd35: u = mk(OP_MUL, SRC_RAM, R_U, SRC_RAM, R_X, R_Y, CAP_EN, 1'b0, 1'b0);
			6'd36: u = mk(OP_MOV, SRC_RHO, R_X, SRC_RAM, R_X, R_PL_RHO, CAP_NONE, 1'b0, 1'b0);
			6'd37: u = mk(OP_MOV, SRC_MOM, R_X, SRC_RAM, R_X, R_PL_M, CAP_NONE, 1'b0, 1'b0);
			6'd38: u = mk(OP_MOV, SRC_EN, R_X, SRC_RAM, R_X, R_PL_E, CAP_NONE, 1'b0, 1'b0);
			6'd39: u = mk(OP_MOV, SRC_RAM, R_NA1, SRC_RAM, R_X, R_PL_A1, CAP_NONE, 1'b0, 1'b0);
			6'd40: u = mk(OP_MOV, SRC_RAM, R_NA2, SRC_RAM, R_X, R_PL_A2, CAP_NONE, 1'b0, 1'b1);
			default: u = mk(OP_MOV, SRC_RAM, R_X, SRC_RAM, R_X, R_X, CAP_NONE, 1'b0, 1'b1);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/elw_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module elw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      wr_en,
	input  wire [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire [WIDTH-1:0]          wr_data,
	input  wire [$clog2(DEPTH)-1:0]  rd_addr_a,
	output logic [WIDTH-1:0]         rd_data_a,
	input  wire [$clog2(DEPTH)-1:0]  rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule
`default_nettype wire

FILE: hdl/euler_lax_wendroff_flux.sv
// Top level of the one-dimensional Euler Lax-Wendroff interface flux block.
`timescale 1ns / 1ps
`default_nettype none
`include "euler_lax_wendroff_flux_defines.svh"
// Each input item is one cell; every cell that follows another cell of the same row
// gives one item of interface fluxes. All arithmetic runs on one shared unit under a
// short operation sequence, with the working values held in a 16-entry register RAM.
// An add or subtract is issued and executed, a multiply then writes back its product,
// and a division works out one quotient bit per cycle over 48 bits before write-back.
// A cell that gives a result runs the whole sequence with three divisions; the input
// stalls while an item is worked on; a finished result waits in an output register.
module euler_lax_wendroff_flux (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  elw_pkg::in_item_t     in_item,
	output logic                  out_valid,
	input  wire                   out_stall,
	output elw_pkg::out_item_t    out_item,
	input  wire                   cfg_we,
	input  wire                   cfg_index,
	input  wire [30:0]            cfg_data
);
	import elw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_ISSUE, S_EXEC, S_MULW, S_DIV, S_DIVW, S_DONE
	} state_t;

	state_t                   state_q;
	logic [PC_W-1:0]          pc_q;
	logic [CW-1:0]            alpha_q;
	logic [CW-1:0]            gamma_q;
	in_item_t                 in_q;
	logic                     prev_valid_q;
	logic                     emit_q;
	logic                     fault_q;
	logic signed [DW-1:0]     res_mass_q;
	logic signed [DW-1:0]     res_mom_q;
	logic signed [DW-1:0]     res_en_q;
	out_item_t                out_q;
	logic                     out_valid_q;
	logic signed [PW-1:0]     prod_q;
	logic [QW-1:0]            num_q;
	logic [DW-1:0]            rem_q;
	logic [DW-2:0]            den_q;
	logic                     neg_q;
	logic [DIV_CNT_W-1:0]     div_cnt_q;

	uop_t                     cur;
	logic [DW-1:0]            ram_a;
	logic [DW-1:0]            ram_b;
	logic signed [DW-1:0]     a_val;
	logic signed [DW-1:0]     b_val;
	logic signed [DW:0]       sum_w;
	logic                     wb_en;
	logic signed [DW-1:0]     wb_val;
	logic                     wb_fault;
	logic [DW-1:0]            rem_sh;
	logic                     q_bit;
	logic [DW-1:0]            a_abs;
	logic                     accept;

	assign cur = prog(pc_q);
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	elw_ram #(
		.WIDTH(DW),
		.DEPTH(REG_DEPTH)
	) u_regs (
		.clk      (clk),
		.wr_en    (wb_en),
		.wr_addr  (cur.dst),
		.wr_data  (wb_val),
		.rd_addr_a(cur.a_reg),
		.rd_data_a(ram_a),
		.rd_addr_b(cur.b_reg),
		.rd_data_b(ram_b)
	);

	always_comb begin
		unique case (cur.a_src)
			SRC_RAM:   a_val = $signed(ram_a);
			SRC_RHO:   a_val = $signed({1'b0, in_q.cell_density});
			SRC_MOM:   a_val = in_q.cell_momentum;
			SRC_EN:    a_val = in_q.cell_energy;
			SRC_ALPHA: a_val = $signed({1'b0, alpha_q});
			SRC_GAMMA: a_val = $signed({1'b0, gamma_q});
			default:   a_val = $signed(ram_a);
		endcase
		unique case (cur.b_src)
			SRC_RAM:   b_val = $signed(ram_b);
			SRC_RHO:   b_val = $signed({1'b0, in_q.cell_density});
			SRC_MOM:   b_val = in_q.cell_momentum;
			SRC_EN:    b_val = in_q.cell_energy;
			SRC_ALPHA: b_val = $signed({1'b0, alpha_q});
			SRC_GAMMA: b_val = $signed({1'b0, gamma_q});
			default:   b_val = $signed(ram_b);
		endcase
	end

	always_comb begin
		if (cur.op == OP_SUB) begin
			sum_w = $signed({a_val[DW-1], a_val}) - $signed({b_val[DW-1], b_val});
		end else begin
			sum_w = $signed({a_val[DW-1], a_val}) + $signed({b_val[DW-1], b_val});
		end
		a_abs = a_val[DW-1] ? DW'(-a_val) : DW'(a_val);
		rem_sh = {rem_q[DW-2:0], num_q[QW-1]};
		q_bit = (rem_sh >= {1'b0, den_q});
	end

	always_comb begin
		wb_en = 1'b0;
		wb_val = a_val;
		wb_fault = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				unique case (cur.op)
					OP_MOV: begin
						wb_en = 1'b1;
					end
					OP_ADD, OP_SUB: begin
						wb_en = 1'b1;
						if (sum_w[DW] != sum_w[DW-1]) begin
							wb_fault = 1'b1;
							wb_val = sum_w[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
						end else begin
							wb_val = sum_w[DW-1:0];
						end
					end
					OP_AVG: begin
						wb_en = 1'b1;
						wb_val = sum_w[DW:1];
					end
					OP_HALF: begin
						wb_en = 1'b1;
						wb_val = a_val >>> 1;
					end
					OP_DIV: begin
						if (b_val <= 0) begin
							wb_en = 1'b1;
							wb_fault = 1'b1;
							wb_val = a_val[DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
						end
					end
					default: begin
					end
				endcase
			end
			S_MULW: begin
				wb_en = 1'b1;
				if ((&prod_q[PW-1:QW-1]) || !(|prod_q[PW-1:QW-1])) begin
					wb_val = prod_q[QW-1:FW];
				end else begin
					wb_fault = 1'b1;
					wb_val = prod_q[PW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
				end
			end
			S_DIVW: begin
				wb_en = 1'b1;
				if (neg_q) begin
					if (num_q > QW'({1'b1, {(DW-1){1'b0}}})) begin
						wb_fault = 1'b1;
						wb_val = {1'b1, {(DW-1){1'b0}}};
					end else begin
						wb_val = -$signed(num_q[DW-1:0]);
					end
				end else begin
					if (|num_q[QW-1:DW-1]) begin
						wb_fault = 1'b1;
						wb_val = {1'b0, {(DW-1){1'b1}}};
					end else begin
						wb_val = $signed(num_q[DW-1:0]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			alpha_q <= '0;
			gamma_q <= GAMMA_RESET;
			prev_valid_q <= 1'b0;
			emit_q <= 1'b0;
			fault_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HALF_DT) begin
					alpha_q <= cfg_data;
				end else begin
					gamma_q <= cfg_data;
				end
			end
			if (out_valid_q && !out_stall && !(state_q == S_DONE && emit_q)) begin
				out_valid_q <= 1'b0;
			end
			if (wb_en) begin
				fault_q <= fault_q | wb_fault;
				unique case (cur.cap)
					CAP_MASS: res_mass_q <= wb_val;
					CAP_MOM:  res_mom_q <= wb_val;
					CAP_EN:   res_en_q <= wb_val;
					default: begin
					end
				endcase
				if (cur.last) begin
					state_q <= S_DONE;
				end else begin
					state_q <= S_ISSUE;
					if (cur.br && !emit_q) begin
						pc_q <= STORE_PC;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_q <= in_item;
						emit_q <= !in_item.row_start && prev_valid_q;
						fault_q <= 1'b0;
						pc_q <= '0;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cur.op == OP_MUL) begin
						prod_q <= PW'(a_val) * PW'(b_val);
						state_q <= S_MULW;
					end else if (cur.op == OP_DIV && b_val > 0) begin
						neg_q <= a_val[DW-1];
						num_q <= {a_abs, {FW{1'b0}}};
						rem_q <= '0;
						den_q <= b_val[DW-2:0];
						div_cnt_q <= DIV_CNT_W'(QW);
						state_q <= S_DIV;
					end
				end
				S_MULW: begin
				end
				S_DIV: begin
					num_q <= {num_q[QW-2:0], q_bit};
					rem_q <= q_bit ? rem_sh - {1'b0, den_q} : rem_sh;
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == DIV_CNT_W'(1)) begin
						state_q <= S_DIVW;
					end
				end
				S_DIVW: begin
				end
				S_DONE: begin
					prev_valid_q <= 1'b1;
					if (!emit_q) begin
						state_q <= S_IDLE;
					end else if (!out_valid_q || !out_stall) begin
						out_q <= {res_mass_q, res_mom_q, res_en_q, fault_q};
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ELW_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, (state_q == S_ISSUE) && (pc_q == '0))
	`ELW_ASSERT_IMP(a_div_count, clk, arst_n, state_q == S_DIV, div_cnt_q != '0)
	`ELW_ASSERT_NEXT(a_no_emit_idle, clk, arst_n, (state_q == S_DONE) && !emit_q, state_q == S_IDLE)
	`ELW_ASSERT_IMP(a_out_from_emit, clk, arst_n, $rose(out_valid_q), $past(emit_q))

endmodule
`default_nettype wire

FILE: bench/euler_lax_wendroff_flux_tb.sv
// Self-checking testbench for the Lax-Wendroff interface flux block.
`timescale 1ns / 1ps
module euler_lax_wendroff_flux_tb;
	import elw_pkg::*;

	localparam longint VMAX = 64'sd2147483647;
	localparam longint VMIN = -64'sd2147483648;
	localparam longint ONE_Q = 64'sd65536;
	localparam int DRAIN_CYCLES = 150;

	typedef struct {
		in_item_t item_in;
		bit lit;
		out_item_t flux;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_HALF_DT;
	logic [30:0] cfg_data = '0;

	longint alpha_q, gm1_q;
	longint left_rho, left_m, left_e, left_a1, left_a2;
	bit left_valid;
	bit flt;
	out_item_t pending_fluxes[$];
	int errors = 0;
	int fluxes_checked = 0;
	int cells_sent = 0;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;

	euler_lax_wendroff_flux u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint sat(longint x);
		if (x > VMAX) begin
			flt = 1'b1;
			return VMAX;
		end
		if (x < VMIN) begin
			flt = 1'b1;
			return VMIN;
		end
		return x;
	endfunction

	function automatic longint floor_div(longint x, longint d);
		longint q;
		q = x / d;
		if ((x % d) != 0 && x < 0)
			q--;
		return q;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return sat(floor_div(a * b, ONE_Q));
	endfunction

	function automatic longint qdiv(longint a, longint b);
		if (b <= 0) begin
			flt = 1'b1;
			return (a >= 0) ? VMAX : VMIN;
		end
		return sat((a * ONE_Q) / b);
	endfunction

	function automatic void state_terms(longint rho, longint m, longint e,
			output longint u, output longint p, output longint ke);
		u = qdiv(m, rho);
		ke = qmul(m, u);
		p = qmul(gm1_q, sat(e - floor_div(ke, 2)));
	endfunction

	function automatic void flux_pair(longint rho, longint m, longint e,
			output longint a1, output longint a2);
		longint u, p, ke;
		state_terms(rho, m, e, u, p, ke);
		a1 = sat(ke + p);
		a2 = qmul(u, sat(e + p));
	endfunction

	function automatic longint midpoint(longint l, longint r, longint dl, longint dr);
		longint avg, corr;
		avg = sat(floor_div(l + r, 2));
		corr = qmul(alpha_q, sat(dr - dl));
		return sat(avg - corr);
	endfunction

	// Advances the cell history and returns 1 with the interface fluxes when one is due.
	function automatic bit predict_flux(in_item_t c, output out_item_t f);
		longint rho, m, e, a1, a2, d1, d2, rs, ms, es, us, ps, kes;
		bit emit;
		flt = 1'b0;
		emit = 1'b0;
		f = '0;
		rho = longint'(c.cell_density);
		m = longint'(c.cell_momentum);
		e = longint'(c.cell_energy);
		flux_pair(rho, m, e, a1, a2);
		if (!c.row_start && left_valid) begin
			flux_pair(left_rho, left_m, left_e, d1, d2);
			rs = midpoint(left_rho, rho, left_m, m);
			ms = midpoint(left_m, m, left_a1, a1);
			es = midpoint(left_e, e, left_a2, a2);
			state_terms(rs, ms, es, us, ps, kes);
			f.flux_mass = ms[31:0];
			f.flux_momentum = sat(kes + ps);
			f.flux_energy = qmul(us, sat(es + ps));
			f.arith_fault = flt;
			emit = 1'b1;
		end
		left_rho = rho;
		left_m = m;
		left_e = e;
		left_a1 = a1;
		left_a2 = a2;
		left_valid = 1'b1;
		return emit;
	endfunction

	function automatic in_item_t mk_cell(logic [30:0] rho, logic [31:0] m, logic [31:0] e,
			logic rs);
		in_item_t c;
		c.cell_density = rho;
		c.cell_momentum = m;
		c.cell_energy = e;
		c.row_start = rs;
		return c;
	endfunction

	function automatic in_item_t rand_cell(logic rs);
		logic [31:0] m, e;
		logic [30:0] rho;
		if ($urandom_range(0, 9) == 0) begin
			rho = $urandom();
			m = $urandom();
			e = $urandom();
			if ($urandom_range(0, 3) == 0)
				rho = '0;
		end else begin
			rho = $urandom_range(32'h4000, 32'h40000);
			m = $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
			e = $urandom_range(32'h10000, 32'h100000);
		end
		return mk_cell(rho, m, e, rs);
	endfunction

	task automatic send_cell(in_item_t c, bit lit, out_item_t lit_flux);
		out_item_t f;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		in_valid = 1'b1;
		in_item = c;
		do
			@(posedge clk);
		while (in_stall);
		cells_sent++;
		if (predict_flux(c, f))
			pending_fluxes.push_back(lit ? lit_flux : f);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(logic idx, logic [30:0] val);
		while (pending_fluxes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == CFG_HALF_DT)
			alpha_q = longint'(val);
		else
			gm1_q = longint'(val);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fluxes.size() == 0) begin
				$display("%0t: unexpected flux item %h", $time, out_item);
				errors++;
			end else begin
				out_item_t x;
				x = pending_fluxes.pop_front();
				fluxes_checked++;
				if (x.flux_mass !== out_item.flux_mass) begin
					$display("%0t: flux_mass expected %h actual %h", $time,
						x.flux_mass, out_item.flux_mass);
					errors++;
				end
				if (x.flux_momentum !== out_item.flux_momentum) begin
					$display("%0t: flux_momentum expected %h actual %h", $time,
						x.flux_momentum, out_item.flux_momentum);
					errors++;
				end
				if (x.flux_energy !== out_item.flux_energy) begin
					$display("%0t: flux_energy expected %h actual %h", $time,
						x.flux_energy, out_item.flux_energy);
					errors++;
				end
				if (x.arith_fault !== out_item.arith_fault) begin
					$display("%0t: arith_fault expected %b actual %b", $time,
						x.arith_fault, out_item.arith_fault);
					errors++;
				end
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall = 1'b1;
				repeat (800) @(negedge clk);
				long_hold = 1'b0;
				out_stall = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	initial begin
		#20000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		dir_row_t dir[$];
		out_item_t none;
		int n;
		none = '0;
		alpha_q = 0;
		gm1_q = 26214;
		left_rho = 0;
		left_m = 0;
		left_e = 0;
		left_a1 = 0;
		left_a2 = 0;
		left_valid = 1'b0;

		// A zero cell after zero cell: zero density divides, all fluxes are zero.
		dir.push_back('{mk_cell(0, 0, 0, 0), 1'b0, none});
		dir.push_back('{mk_cell(0, 0, 0, 0), 1'b1, '{0, 0, 0, 1'b1}});
		dir.push_back('{mk_cell(31'h10000, 0, 32'h10000, 1), 1'b0, none});
		dir.push_back('{mk_cell(31'h10000, 32'h8000, 32'h28000, 0), 1'b0, none});
		dir.push_back('{mk_cell(31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0), 1'b0, none});
		dir.push_back('{mk_cell(31'h1, 32'h80000000, 32'h80000000, 0), 1'b0, none});
		dir.push_back('{mk_cell(31'h10000, 32'h80000000, 32'h7fffffff, 0), 1'b0, none});
		dir.push_back('{mk_cell(0, 32'h10000, 32'hffff0000, 0), 1'b0, none});
		dir.push_back('{mk_cell(31'h20000, 32'hffff8000, 32'h30000, 0), 1'b0, none});
		dir.push_back('{mk_cell(31'h18000, 32'h4000, 32'h28000, 1), 1'b0, none});
		dir.push_back('{mk_cell(31'h18000, 32'h4000, 32'h28000, 0), 1'b0, none});
		dir.push_back('{mk_cell(31'h7fffffff, 32'h0, 32'h0, 0), 1'b0, none});

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir[i])
			send_cell(dir[i].item_in, dir[i].lit, dir[i].flux);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(CFG_HALF_DT, 31'h4000);
				end
				1: begin
					write_reg(CFG_HALF_DT, 31'h7fffffff);
					write_reg(CFG_GAMMA, 31'h7fffffff);
					long_hold = 1'b1;
				end
				2: begin
					write_reg(CFG_HALF_DT, 31'h0);
					write_reg(CFG_GAMMA, 31'h0);
				end
				3: begin
					write_reg(CFG_HALF_DT, $urandom());
					write_reg(CFG_GAMMA, $urandom());
				end
				4: begin
					write_reg(CFG_HALF_DT, $urandom_range(0, 32'h8000));
					write_reg(CFG_GAMMA, 31'h6666);
				end
				default: begin
					write_reg(CFG_HALF_DT, 31'h2000);
					quiet = 1'b1;
				end
			endcase
			n = 0;
			while (n < 250) begin
				int row_len;
				row_len = $urandom_range(1, 8);
				send_cell(rand_cell(($urandom_range(0, 15) == 0) ? 1'b0 : 1'b1), 1'b0, none);
				for (int k = 1; k < row_len; k++)
					send_cell(rand_cell(1'b0), 1'b0, none);
				n += row_len;
			end
		end

		while (pending_fluxes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d cells over six register settings, checked %0d flux items.",
			cells_sent, fluxes_checked);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
